[hdl/pvm_pkg.sv]
// ----------------------------------------------------------------------------
// pvm_pkg: shared types and constants of the PCM voice mixer
// Voice count, sample memory geometry, output rate, command codes and the
// layout of one voice state entry.
// ----------------------------------------------------------------------------
package pvm_pkg;

	// number of voices (1 to 8)
	localparam int VOICES = 8;
	// sample memory depth in bytes, a power of two (256 to 64K)
	localparam int SAMPLE_MEM_DEPTH = 65536;
	// output sample rate in Hz
	localparam int OUTPUT_RATE = 22050;

	localparam int VOICE_IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SMEM_AW  = $clog2(SAMPLE_MEM_DEPTH);
	localparam int ACC_W    = 16 + $clog2(VOICES);

	localparam int POS_W  = 25;
	localparam int STEP_W = 16;
	localparam int LEN_W  = 16;
	localparam int BASE_W = 16;

	// floor(2^32 / OUTPUT_RATE), used to divide by the output rate
	localparam longint unsigned RECIP = (64'd1 << 32) / OUTPUT_RATE;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_LOAD  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_TICK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [STEP_W-1:0] step;
		logic [LEN_W-1:0]  length;
		logic [BASE_W-1:0] base;
	} voice_t;

endpackage

[hdl/pvm_sample_mem.sv]
// ----------------------------------------------------------------------------
// pvm_sample_mem: shared sample byte memory
// One write port for loads, one read port with registered data for the mix.
// ----------------------------------------------------------------------------
module pvm_sample_mem (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [pvm_pkg::SMEM_AW-1:0] wr_addr,
	input  logic [7:0]                  wr_data,
	input  logic                        rd_en,
	input  logic [pvm_pkg::SMEM_AW-1:0] rd_addr,
	output logic [7:0]                  rd_data
);
	import pvm_pkg::*;

	logic [7:0] mem [SAMPLE_MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/pvm_voice_mem.sv]
// ----------------------------------------------------------------------------
// pvm_voice_mem: per-voice playback state
// Position, step, length and base of each voice, one entry per voice,
// one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module pvm_voice_mem (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [pvm_pkg::VOICE_IW-1:0] wr_addr,
	input  pvm_pkg::voice_t              wr_data,
	input  logic                         rd_en,
	input  logic [pvm_pkg::VOICE_IW-1:0] rd_addr,
	output pvm_pkg::voice_t              rd_data
);
	import pvm_pkg::*;

	voice_t mem [VOICES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/pvm_step_calc.sv]
// ----------------------------------------------------------------------------
// pvm_step_calc: playback step from a source sample rate
// Computes (rate << 8) / OUTPUT_RATE in three stages: reciprocal multiply,
// back-multiply, then a single correction by compare and increment.
// ----------------------------------------------------------------------------
module pvm_step_calc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [15:0]                rate,
	output logic                       done,
	output logic [pvm_pkg::STEP_W-1:0] step
);
	import pvm_pkg::*;

	localparam logic [31:0] RECIP32 = 32'(RECIP);
	localparam logic [23:0] RATE24  = 24'(OUTPUT_RATE);

	logic        vld_s1, vld_s2, vld_s3;
	logic [23:0] x_s1, x_s2;
	logic [55:0] prod_s1;
	logic [23:0] qe_s2, back_s2;
	logic [23:0] rem;
	logic [23:0] q;
	logic [STEP_W-1:0] step_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// estimate is the true quotient or one below it
	always_ff @(posedge clk) begin
		x_s1    <= {rate, 8'd0};
		prod_s1 <= {32'd0, rate, 8'd0} * {24'd0, RECIP32};
		x_s2    <= x_s1;
		qe_s2   <= prod_s1[55:32];
		back_s2 <= 24'(prod_s1[55:32] * RATE24);
		step_s3 <= q[STEP_W-1:0];
	end

	always_comb begin
		rem = x_s2 - back_s2;
		q   = (rem >= RATE24) ? qe_s2 + 24'd1 : qe_s2;
	end

	assign done = vld_s3;
	assign step = step_s3;

endmodule

[hdl/pcm_voice_mixer.sv]
// ----------------------------------------------------------------------------
// pcm_voice_mixer: multi-voice 8-bit PCM sample mixer
// Sample memory, voice state memory and the tick/start/load sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   One input channel (s_*) carries commands, the kind in s_tuser: tick,
//   start voice, load sample byte. One output channel (m_*) carries one
//   mixed sample and the mask of still playing voices for every tick.
//   A load is taken while idle and the next item may follow at once.
//   A start holds off further items while the step is worked out by a
//   three-stage reciprocal divider, then the voice entry is written.
//   A tick visits the voices one per cycle through the voice state memory
//   (read, sample fetch, write-back, accumulate); its result is loaded
//   into the output register once the pipeline has drained and the
//   register is free, and the next item is taken in the following cycle.
//   Reset clears all voices to inactive and empties the output register;
//   sample memory contents are undefined until loaded.
//   When the receiver stalls, the result waits in the output register
//   while loads and starts are still accepted; a following tick finishes
//   its mix and holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module pcm_voice_mixer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// voice[2:0], sample_rate[18:3], sample_count[34:19],
	// start_address[50:35], load_address[66:51], load_data[74:67], zero fill
	input  logic [79:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mix_sample[15:0], active_mask[23:16]
	output logic [23:0] m_tdata
);
	import pvm_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);
	localparam logic [VOICE_IW-1:0] LAST_VOICE = VOICE_IW'(VOICES - 1);

	logic [2:0]  in_voice;
	logic [15:0] in_rate, in_count, in_start, in_laddr;
	logic [7:0]  in_ldata;

	assign in_voice = s_tdata[2:0];
	assign in_rate  = s_tdata[18:3];
	assign in_count = s_tdata[34:19];
	assign in_start = s_tdata[50:35];
	assign in_laddr = s_tdata[66:51];
	assign in_ldata = s_tdata[74:67];

	state_t state_q, state_d;

	logic [VOICE_IW-1:0] vsel_q;
	logic [LEN_W-1:0]    len_q;
	logic [BASE_W-1:0]   base_q;
	logic [VOICE_IW-1:0] cnt_q;
	logic [VOICES-1:0]   active_q;

	logic                vld_s1, vld_s2, act_s2;
	logic [VOICE_IW-1:0] idx_s1;
	logic signed [ACC_W-1:0] acc_q;

	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	// control from the sequencer
	logic start_go, load_we, tick_go, vrd_en, out_load, step_wr;

	logic        step_done;
	logic [STEP_W-1:0] step_val;

	voice_t              vrd, vwr;
	logic                vwr_en;
	logic [VOICE_IW-1:0] vwr_addr;

	logic                act_s1, retire;
	logic [POS_W-1:0]    pos_new;
	logic [17:0]         saddr_sum;
	logic [7:0]          smp;
	logic signed [8:0]   smp_c;
	logic signed [ACC_W-1:0] contrib;
	logic [15:0]         sat;
	logic [7:0]          mask;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		start_go = 1'b0;
		load_we  = 1'b0;
		tick_go  = 1'b0;
		vrd_en   = 1'b0;
		out_load = 1'b0;
		step_wr  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (s_tuser)
						CMD_TICK: begin
							tick_go = 1'b1;
							state_d = ST_TICK;
						end
						CMD_START: begin
							if (32'(in_voice) < VOICES) begin
								start_go = 1'b1;
								state_d  = ST_STEP;
							end
						end
						CMD_LOAD: begin
							load_we = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_STEP: begin
				if (step_done) begin
					step_wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_TICK: begin
				vrd_en = 1'b1;
				if (cnt_q == LAST_VOICE) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold start fields while the step is computed
	always_ff @(posedge clk) begin
		if (start_go) begin
			vsel_q <= VOICE_IW'(in_voice);
			len_q  <= in_count;
			base_q <= in_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (tick_go) begin
			cnt_q <= '0;
		end else if (vrd_en) begin
			cnt_q <= cnt_q + VOICE_IW'(1);
		end
	end

	pvm_step_calc u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_go),
		.rate   (in_rate),
		.done   (step_done),
		.step   (step_val)
	);

	// ---------------- voice pipeline ----------------
	// Each voice is read once per tick and, if active, written back in the next
	// cycle, before any other access to that entry, so no forwarding is needed.
	pvm_voice_mem u_vmem (
		.clk     (clk),
		.wr_en   (vwr_en),
		.wr_addr (vwr_addr),
		.wr_data (vwr),
		.rd_en   (vrd_en),
		.rd_addr (cnt_q),
		.rd_data (vrd)
	);

	always_comb begin
		act_s1    = active_q[idx_s1];
		pos_new   = POS_W'({8'd0, vrd.position} + {{(POS_W - STEP_W){1'b0}}, vrd.step});
		retire    = pos_new >= {1'b0, vrd.length, 8'd0};
		saddr_sum = {2'd0, vrd.base} + {1'b0, vrd.position[POS_W-1:8]};
	end

	always_comb begin
		if (step_wr) begin
			vwr_en        = 1'b1;
			vwr_addr      = vsel_q;
			vwr.position  = '0;
			vwr.step      = step_val;
			vwr.length    = len_q;
			vwr.base      = base_q;
		end else begin
			vwr_en        = vld_s1 && act_s1;
			vwr_addr      = idx_s1;
			vwr.position  = pos_new;
			vwr.step      = vrd.step;
			vwr.length    = vrd.length;
			vwr.base      = vrd.base;
		end
	end

	pvm_sample_mem u_smem (
		.clk     (clk),
		.wr_en   (load_we),
		.wr_addr (SMEM_AW'(in_laddr)),
		.wr_data (in_ldata),
		.rd_en   (vld_s1),
		.rd_addr (SMEM_AW'(saddr_sum)),
		.rd_data (smp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vrd_en;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		act_s2 <= act_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (step_wr) begin
			active_q[vsel_q] <= (len_q != '0);
		end else if (vld_s1 && act_s1 && retire) begin
			active_q[idx_s1] <= 1'b0;
		end
	end

	// center the unsigned byte, scale by 128
	always_comb begin
		smp_c   = $signed({1'b0, smp}) - 9'sd128;
		contrib = ACC_W'({{(ACC_W - 9){smp_c[8]}}, smp_c} << 7);
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			acc_q <= '0;
		end else if (vld_s2 && act_s2) begin
			acc_q <= acc_q + contrib;
		end
	end

	// ---------------- output register ----------------
	always_comb begin
		if (acc_q > SAT_MAX) begin
			sat = 16'h7fff;
		end else if (acc_q < SAT_MIN) begin
			sat = 16'h8000;
		end else begin
			sat = acc_q[15:0];
		end
		mask = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < VOICES) begin
				mask[b] = active_q[VOICE_IW'(b)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {mask, sat};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hdl/pvm_checker.sv]
// ----------------------------------------------------------------------------
// pvm_checker: port-level checks of the PCM voice mixer
// Output hold under stall and sequencing of command items against results.
// ----------------------------------------------------------------------------
module pvm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [79:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import pvm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a tick occupies the block: nothing more is taken the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_TICK |=> !s_tready)
		else $error("item taken right after a tick");

	// a start on an existing voice occupies the block: the input is not ready right after it is taken
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_START && 32'(s_tdata[2:0]) < VOICES
		|=> !s_tready)
		else $error("item taken right after a start");

	// a new result only appears at the end of a tick, when input is held off
	a_out_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while idle");

endmodule

bind pcm_voice_mixer pvm_checker u_pvm_checker (.*);
